[hw/rtl/tis_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types, codes and helpers of the reservation station issue stage.
// ----------------------------------------------------------------------------
package tis_pkg;

	// Number of station slots that can exist; higher numbered stations are absent.
	localparam int StationSlots = 8;
	localparam int StationW     = 3;
	localparam int RegW         = 4;
	localparam int SeqW         = 16;

	// Register alias table is never deeper than the register fields can address.
	localparam int AliasMaxDepth = 16;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_SUB     = 3'd1,
		OP_MUL     = 3'd2,
		OP_DIV     = 3'd3,
		OP_RELEASE = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_ISSUED   = 2'd0,
		STAT_STALLED  = 2'd1,
		STAT_RELEASED = 2'd2,
		STAT_INVALID  = 2'd3
	} status_t;

	typedef enum logic {
		FSM_RUN   = 1'b0,
		FSM_SWEEP = 1'b1
	} fsm_t;

	// One bit for every station with lo <= index < hi.
	function automatic logic [StationSlots-1:0] range_mask(input int lo, input int hi);
		logic [StationSlots-1:0] m;
		m = '0;
		for (int i = 0; i < StationSlots; i++) begin
			m[i] = (i >= lo) && (i < hi);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tomasulo_issue_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tomasulo_issue_stage
// Issue stage of a reservation station scheduler with a register alias table.
// ----------------------------------------------------------------------------
// Usage. Items enter on the issue channel (issue_valid / issue_stall) and each
// item gives exactly one result on the result channel (result_valid /
// result_stall). An item is taken at a rising edge with valid high and stall
// low. An item is an instruction (add, sub, mult, div) or a station release.
// Both sources are read from the alias RAM at the accepting edge; the lookup
// stage then picks the station, resolves the sources and loads the result
// register. Throughput: instructions, stalled or invalid items flow at one
// item per cycle while the receiver does not stall; the alias RAM is read on
// acceptance and a write from the item ahead to the same entry is forwarded.
// A release blocks the input while it is in the lookup stage and then for a
// sweep, which reads every alias entry once and drops the entries naming the
// freed station. The sweep reads the entries one by one through read port a.
// Reset: all stations are free, every alias entry reads as "no producer",
// the instruction number restarts at zero and no sweep is pending.
// When the receiver stalls, the result register holds its item, the item in
// the lookup stage waits behind it and issue_stall rises; one more item can
// still be in flight while a result waits.
// ----------------------------------------------------------------------------
module tomasulo_issue_stage #(
	parameter int ADD_STATIONS = 4,
	parameter int MUL_STATIONS = 2,
	parameter int DIV_STATIONS = 2,
	parameter int NUM_REGS     = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       issue_valid,
	output logic            issue_stall,
	input  wire logic [2:0] opcode,
	input  wire logic [3:0] src1_reg,
	input  wire logic [3:0] src2_reg,
	input  wire logic [3:0] dest_reg,
	input  wire logic [2:0] release_station,

	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      status,
	output logic [2:0]      station,
	output logic            src1_ready,
	output logic [2:0]      src1_tag,
	output logic [3:0]      src1_value,
	output logic            src2_ready,
	output logic [2:0]      src2_tag,
	output logic [3:0]      src2_value,
	output logic [15:0]     inst_number
);

	import tis_pkg::*;

	// Only the first sixteen registers can be named, so the table stops there.
	localparam int AliasDepth = (NUM_REGS < AliasMaxDepth) ? NUM_REGS : AliasMaxDepth;
	localparam int AW         = (AliasDepth > 1) ? $clog2(AliasDepth) : 1;
	localparam int CW         = $clog2(AliasDepth + 1);

	localparam logic [StationSlots-1:0] AddMask =
		range_mask(0, ADD_STATIONS);
	localparam logic [StationSlots-1:0] MulMask =
		range_mask(ADD_STATIONS, ADD_STATIONS + MUL_STATIONS);
	localparam logic [StationSlots-1:0] DivMask =
		range_mask(ADD_STATIONS + MUL_STATIONS,
		           ADD_STATIONS + MUL_STATIONS + DIV_STATIONS);

	// Control state.
	fsm_t                    state_q, state_d;
	logic [StationSlots-1:0] busy_q;
	logic [AliasDepth-1:0]   alias_vld_q;
	logic [SeqW-1:0]         issue_cnt_q;
	logic [CW-1:0]           sweep_cnt_q;
	logic                    chk_valid_q;
	logic [AW-1:0]           chk_addr_q;
	logic [StationW-1:0]     rel_q;

	// Lookup stage.
	logic                    s1_valid_q;
	logic [2:0]              op_s1;
	logic [RegW-1:0]         src1_s1;
	logic [RegW-1:0]         src2_s1;
	logic [RegW-1:0]         dest_s1;
	logic [StationW-1:0]     rel_s1;
	logic                    fwd1_s1;
	logic                    fwd2_s1;
	logic [StationW-1:0]     fwd_data_s1;

	// Result register.
	logic                    out_valid_q;
	status_t                 status_q;
	logic [StationW-1:0]     station_q;
	logic                    rdy1_q, rdy2_q;
	logic [StationW-1:0]     tag1_q, tag2_q;
	logic [RegW-1:0]         val1_q, val2_q;
	logic [SeqW-1:0]         num_q;

	// Combinational.
	logic                    accept;
	logic                    in_ready;
	logic                    s1_adv;
	logic                    s1_release;
	logic                    sweep_read;
	logic                    sweep_clear;
	logic [StationSlots-1:0] class_mask;
	logic [StationSlots-1:0] free_vec;
	logic [StationW-1:0]     found;
	logic                    is_instr;
	logic                    issue_ok;
	status_t                 status_d;
	logic                    in_tbl1, in_tbl2, dest_in_tbl;
	logic [StationW-1:0]     alias1, alias2;
	logic                    pend1, pend2;
	logic                    ram_we;
	logic [AW-1:0]           ram_raddr_a;
	logic [StationW-1:0]     ram_rdata_a;
	logic [StationW-1:0]     ram_rdata_b;
	logic                    acc_in_tbl1, acc_in_tbl2;

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign s1_adv     = s1_valid_q && (!out_valid_q || !result_stall);
	assign s1_release = (op_s1 == OP_RELEASE);
	// A release in the lookup stage keeps the input closed so the sweep
	// finishes before any later item reads the table.
	assign in_ready   = (state_q == FSM_RUN) && (!s1_valid_q || (s1_adv && !s1_release));
	assign issue_stall = !in_ready;
	assign accept      = issue_valid && in_ready;

	// ------------------------------------------------------------------
	// Alias RAM: holds the producing station of each register. Whether
	// an entry names a producer at all is kept in alias_vld_q.
	// ------------------------------------------------------------------
	assign sweep_read  = (state_q == FSM_SWEEP) && (sweep_cnt_q < CW'(AliasDepth));
	assign ram_raddr_a = accept ? src1_reg[AW-1:0] : sweep_cnt_q[AW-1:0];
	assign ram_we      = s1_adv && issue_ok && dest_in_tbl;

	tis_ram #(
		.WIDTH (StationW),
		.DEPTH (AliasDepth)
	) u_alias_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (dest_s1[AW-1:0]),
		.wdata   (found),
		.re_a    (accept || sweep_read),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.re_b    (accept),
		.raddr_b (src2_reg[AW-1:0]),
		.rdata_b (ram_rdata_b)
	);

	assign acc_in_tbl1 = {1'b0, src1_reg} < (RegW + 1)'(AliasDepth);
	assign acc_in_tbl2 = {1'b0, src2_reg} < (RegW + 1)'(AliasDepth);

	// ------------------------------------------------------------------
	// Lookup stage register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// The item ahead writes its destination at the edge this item reads its
	// sources; the RAM returns the old entry, so the new one is forwarded.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= opcode;
			src1_s1     <= src1_reg;
			src2_s1     <= src2_reg;
			dest_s1     <= dest_reg;
			rel_s1      <= release_station;
			fwd1_s1     <= ram_we && acc_in_tbl1 && (dest_s1[AW-1:0] == src1_reg[AW-1:0]);
			fwd2_s1     <= ram_we && acc_in_tbl2 && (dest_s1[AW-1:0] == src2_reg[AW-1:0]);
			fwd_data_s1 <= found;
		end
	end

	// ------------------------------------------------------------------
	// Station choice and source resolution
	// ------------------------------------------------------------------
	always_comb begin
		class_mask = '0;
		is_instr   = 1'b0;
		case (op_s1)
			OP_ADD, OP_SUB: begin
				class_mask = AddMask;
				is_instr   = 1'b1;
			end
			OP_MUL: begin
				class_mask = MulMask;
				is_instr   = 1'b1;
			end
			OP_DIV: begin
				class_mask = DivMask;
				is_instr   = 1'b1;
			end
			default: begin
				class_mask = '0;
				is_instr   = 1'b0;
			end
		endcase

		// Lowest free station of the class wins.
		free_vec = class_mask & ~busy_q;
		found    = '0;
		for (int i = StationSlots - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				found = StationW'(i);
			end
		end
		issue_ok = is_instr && (|free_vec);

		case (op_s1)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: status_d = (|free_vec) ? STAT_ISSUED : STAT_STALLED;
			OP_RELEASE:                     status_d = STAT_RELEASED;
			default:                        status_d = STAT_INVALID;
		endcase
	end

	assign in_tbl1     = {1'b0, src1_s1} < (RegW + 1)'(AliasDepth);
	assign in_tbl2     = {1'b0, src2_s1} < (RegW + 1)'(AliasDepth);
	assign dest_in_tbl = {1'b0, dest_s1} < (RegW + 1)'(AliasDepth);
	assign alias1      = fwd1_s1 ? fwd_data_s1 : ram_rdata_a;
	assign alias2      = fwd2_s1 ? fwd_data_s1 : ram_rdata_b;
	assign pend1       = in_tbl1 && alias_vld_q[src1_s1[AW-1:0]];
	assign pend2       = in_tbl2 && alias_vld_q[src2_s1[AW-1:0]];

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q  <= status_d;
			station_q <= issue_ok ? found : (s1_release ? rel_s1 : '0);
			rdy1_q    <= issue_ok && !pend1;
			tag1_q    <= (issue_ok && pend1) ? alias1 : '0;
			val1_q    <= (issue_ok && !pend1) ? src1_s1 : '0;
			rdy2_q    <= issue_ok && !pend2;
			tag2_q    <= (issue_ok && pend2) ? alias2 : '0;
			val2_q    <= (issue_ok && !pend2) ? src2_s1 : '0;
			num_q     <= issue_ok ? issue_cnt_q : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign station      = station_q;
	assign src1_ready   = rdy1_q;
	assign src1_tag     = tag1_q;
	assign src1_value   = val1_q;
	assign src2_ready   = rdy2_q;
	assign src2_tag     = tag2_q;
	assign src2_value   = val2_q;
	assign inst_number  = num_q;

	// ------------------------------------------------------------------
	// Station table, alias valid bits and instruction counter
	// ------------------------------------------------------------------
	assign sweep_clear = chk_valid_q && alias_vld_q[chk_addr_q] && (ram_rdata_a == rel_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			alias_vld_q <= '0;
			issue_cnt_q <= '0;
		end else begin
			if (s1_adv && issue_ok) begin
				busy_q[found] <= 1'b1;
				issue_cnt_q   <= issue_cnt_q + SeqW'(1);
			end else if (s1_adv && s1_release) begin
				busy_q[rel_s1] <= 1'b0;
			end
			if (ram_we) begin
				alias_vld_q[dest_s1[AW-1:0]] <= 1'b1;
			end else if (sweep_clear) begin
				alias_vld_q[chk_addr_q] <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Release sweep: read each alias entry, check it in the following cycle.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_RUN: begin
				if (s1_adv && s1_release) begin
					state_d = FSM_SWEEP;
				end
			end
			FSM_SWEEP: begin
				if (sweep_cnt_q == CW'(AliasDepth)) begin
					state_d = FSM_RUN;
				end
			end
			default: begin
				state_d = FSM_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_RUN;
			sweep_cnt_q <= '0;
			chk_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			chk_valid_q <= sweep_read;
			if (state_q == FSM_RUN) begin
				sweep_cnt_q <= '0;
			end else if (sweep_cnt_q != CW'(AliasDepth)) begin
				sweep_cnt_q <= sweep_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_q <= sweep_cnt_q[AW-1:0];
		if (s1_adv && s1_release) begin
			rel_q <= rel_s1;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A pending source always names a station that is still busy.
	a_tag1_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && issue_ok && pend1) |-> busy_q[alias1])
		else $error("source 1 names a free station");

	a_tag2_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && issue_ok && pend2) |-> busy_q[alias2])
		else $error("source 2 names a free station");

	// The sweep has a fixed length.
	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == FSM_SWEEP) |-> ##(AliasDepth + 1) (state_q == FSM_RUN))
		else $error("alias sweep length wrong");

	// No table write may race the sweep.
	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SWEEP) |-> (!ram_we && !s1_valid_q))
		else $error("alias write during sweep");

	// Instruction numbers advance once per issued instruction.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && issue_ok) |=> (issue_cnt_q == $past(issue_cnt_q) + SeqW'(1)))
		else $error("instruction number did not advance");

endmodule
`default_nettype wire

[hw/rtl/tis_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tis_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tis_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re_a,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic             re_b,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read in the cycle of a write to the same entry returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire
